/* rtl/assert_macros.svh */
// Assertion macros shared by the stack evaluator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define SEV_ASSERT(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("sev assertion failed");

// Check that the consequent holds in the same cycle as the antecedent.
`define SEV_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sev assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define SEV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sev assertion failed");

`else

`define SEV_ASSERT(lbl, clk, rst, cond)
`define SEV_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define SEV_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* rtl/sev_pkg.sv */
// Types and constants shared by the stack evaluator modules.
package sev_pkg;

   localparam int DATA_W      = 32;
   localparam int CMD_W       = 3;
   localparam int FAULT_W     = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;
   localparam int REQ_PAD_W   = REQ_TDATA_W - CMD_W - DATA_W;
   localparam int RSP_PAD_W   = RSP_TDATA_W - 1 - DATA_W - 1 - FAULT_W;

   typedef logic [CMD_W-1:0]   cmd_type;
   typedef logic [FAULT_W-1:0] fault_type;
   typedef logic [DATA_W-1:0]  word_type;
   typedef logic [1:0]         alu_op_type;

   localparam cmd_type CMD_NOP   = 3'd0;
   localparam cmd_type CMD_PUSH  = 3'd1;
   localparam cmd_type CMD_ADD   = 3'd2;
   localparam cmd_type CMD_MUL   = 3'd3;
   localparam cmd_type CMD_MOD   = 3'd4;
   localparam cmd_type CMD_CPOP  = 3'd5;
   localparam cmd_type CMD_PRINT = 3'd6;

   localparam fault_type FAULT_NONE  = 2'd0;
   localparam fault_type FAULT_UNDER = 2'd1;
   localparam fault_type FAULT_OVER  = 2'd2;
   localparam fault_type FAULT_DIVZ  = 2'd3;

   localparam alu_op_type ALU_ADD  = 2'd0;
   localparam alu_op_type ALU_MUL  = 2'd1;
   localparam alu_op_type ALU_MOD  = 2'd2;
   localparam alu_op_type ALU_NONE = 2'd3;

   typedef struct packed {
      logic       start;
      alu_op_type op;
      word_type   a;
      word_type   b;
   } alu_req_type;

   typedef struct packed {
      logic     done;
      word_type result;
   } alu_rsp_type;

endpackage

/* rtl/sev_stack_ram.sv */
// Stack storage: one write port and one registered read port.
module sev_stack_ram #(
   parameter int DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  sev_pkg::word_type          wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output sev_pkg::word_type          rd_data
);

   sev_pkg::word_type mem_ff [DEPTH];
   sev_pkg::word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sev_alu.sv */
// Shared arithmetic unit: add, shift-add multiply and restoring signed modulo.
module sev_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  sev_pkg::alu_req_type alu_req,
   output sev_pkg::alu_rsp_type alu_rsp
);

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_ABSA = 3'd1;
   localparam logic [2:0] PH_ABSB = 3'd2;
   localparam logic [2:0] PH_ITER = 3'd3;
   localparam logic [2:0] PH_SIGN = 3'd4;

   localparam logic [4:0] ITER_LAST = 5'd31;

   logic [2:0]          phase_ff, phase_in;
   logic [4:0]          cnt_ff, cnt_in;
   sev_pkg::alu_op_type op_ff, op_in;
   sev_pkg::word_type   acc_ff, acc_in;
   sev_pkg::word_type   opa_ff, opa_in;
   sev_pkg::word_type   opb_ff, opb_in;
   logic                neg_ff, neg_in;
   logic                done_ff, done_in;
   sev_pkg::word_type   res_ff, res_in;

   logic [32:0] add_x;
   logic [32:0] add_y;
   logic        add_sub;
   logic [33:0] add_res;
   logic [32:0] rem_sh;

   assign rem_sh = {acc_ff, opa_ff[31]};

   // Select operands of the one shared adder
   always_comb begin
      add_x   = 33'd0;
      add_y   = 33'd0;
      add_sub = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            add_x = {1'b0, alu_req.a};
            add_y = {1'b0, alu_req.b};
         end
         PH_ABSA: begin
            add_y   = {1'b0, opa_ff};
            add_sub = 1'b1;
         end
         PH_ABSB: begin
            add_y   = {1'b0, opb_ff};
            add_sub = 1'b1;
         end
         PH_ITER: begin
            if (op_ff == sev_pkg::ALU_MUL) begin
               add_x = {1'b0, acc_ff};
               add_y = opb_ff[0] ? {1'b0, opa_ff} : 33'd0;
            end else begin
               add_x   = rem_sh;
               add_y   = {1'b0, opb_ff};
               add_sub = 1'b1;
            end
         end
         PH_SIGN: begin
            add_y   = {1'b0, acc_ff};
            add_sub = 1'b1;
         end
         default: begin
            add_x = 33'd0;
         end
      endcase
   end

   assign add_res = {1'b0, add_x} + ({1'b0, add_y} ^ {34{add_sub}}) + {33'd0, add_sub};

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      acc_in   = acc_ff;
      opa_in   = opa_ff;
      opb_in   = opb_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (alu_req.start) begin
               op_in = alu_req.op;
               unique case (alu_req.op)
                  sev_pkg::ALU_ADD: begin
                     res_in  = add_res[31:0];
                     done_in = 1'b1;
                  end
                  sev_pkg::ALU_MUL: begin
                     acc_in   = '0;
                     opa_in   = alu_req.a;
                     opb_in   = alu_req.b;
                     cnt_in   = '0;
                     phase_in = PH_ITER;
                  end
                  sev_pkg::ALU_MOD: begin
                     opa_in   = alu_req.a;
                     opb_in   = alu_req.b;
                     neg_in   = alu_req.a[31];
                     phase_in = PH_ABSA;
                  end
                  default: begin
                     res_in  = '0;
                     done_in = 1'b1;
                  end
               endcase
            end
         end
         PH_ABSA: begin
            if (opa_ff[31]) begin
               opa_in = add_res[31:0];
            end
            phase_in = PH_ABSB;
         end
         PH_ABSB: begin
            if (opb_ff[31]) begin
               opb_in = add_res[31:0];
            end
            acc_in   = '0;
            cnt_in   = '0;
            phase_in = PH_ITER;
         end
         PH_ITER: begin
            cnt_in = cnt_ff + 5'd1;
            opa_in = {opa_ff[30:0], 1'b0};
            if (op_ff == sev_pkg::ALU_MUL) begin
               acc_in = add_res[31:0];
               opb_in = {1'b0, opb_ff[31:1]};
               if (cnt_ff == ITER_LAST) begin
                  res_in   = add_res[31:0];
                  done_in  = 1'b1;
                  phase_in = PH_IDLE;
               end
            end else begin
               // restore on borrow
               acc_in = add_res[33] ? rem_sh[31:0] : add_res[31:0];
               if (cnt_ff == ITER_LAST) begin
                  phase_in = PH_SIGN;
               end
            end
         end
         PH_SIGN: begin
            // remainder takes the sign of the dividend
            res_in   = neg_ff ? add_res[31:0] : acc_ff;
            done_in  = 1'b1;
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      op_ff  <= op_in;
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign alu_rsp.done   = done_ff;
   assign alu_rsp.result = res_ff;

endmodule

/* rtl/stack_evaluator.sv */
// Top level of the stack evaluator: sequencer, stack pointer and output register.
//
//  channel  dir  handshake            payload
//  req_     in   req_tvalid/tready    req_tdata : cmd, operand_value
//  rsp_     out  rsp_tvalid/tready    rsp_tdata : emit_valid, emit_value, take_jump, fault
//
// Arithmetic items wait on sev_alu, which runs one shift-add or one
// restoring step per cycle.
// One item is in work at a time; req_tready is high only while the sequencer idles.
// A finished item waits in the output register; a stalled rsp_tready holds it there.
// Reset clears the stack pointer, the sequencer and the output valid flag; stack entries are never cleared.
`include "assert_macros.svh"

module stack_evaluator #(
   parameter int STACK_DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [2:0] cmd, [34:3] operand_value, [39:35] zero
   input  logic [sev_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] emit_valid, [32:1] emit_value, [33] take_jump, [35:34] fault, [39:36] zero
   output logic [sev_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int TW = $clog2(STACK_DEPTH + 1);
   localparam logic [TW-1:0] TOP_FULL = TW'(STACK_DEPTH);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RDA  = 3'd1; // b arrives, fetch a
   localparam logic [2:0] S_OPS  = 3'd2; // a arrives, launch the unit
   localparam logic [2:0] S_ALU  = 3'd3; // wait for the unit
   localparam logic [2:0] S_RDU  = 3'd4; // single-operand pop
   localparam logic [2:0] S_DONE = 3'd5; // hand the item to the output register

   logic [2:0]           state_ff, state_in;
   sev_pkg::cmd_type     cmd_ff, cmd_in;
   sev_pkg::word_type    b_ff, b_in;
   logic [TW-1:0]        top_ff, top_in;
   logic                 pend_emit_ff, pend_emit_in;
   sev_pkg::word_type    pend_value_ff, pend_value_in;
   logic                 pend_jump_ff, pend_jump_in;
   sev_pkg::fault_type   pend_fault_ff, pend_fault_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [sev_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                 req_accept;
   sev_pkg::cmd_type     req_cmd;
   sev_pkg::word_type    req_operand;
   logic [TW-1:0]        top_m1;
   logic [TW-1:0]        top_m2;
   logic                 out_free;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   sev_pkg::word_type    wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   sev_pkg::word_type    rd_data;

   sev_pkg::alu_req_type alu_req;
   sev_pkg::alu_rsp_type alu_rsp;
   sev_pkg::alu_op_type  alu_op;

   assign req_tready  = (state_ff == S_IDLE);
   assign req_accept  = req_tvalid & req_tready;
   assign req_cmd     = req_tdata[2:0];
   assign req_operand = req_tdata[34:3];
   assign top_m1      = top_ff - TW'(1);
   assign top_m2      = top_ff - TW'(2);
   assign out_free    = ~rsp_valid_ff | rsp_tready;

   // map the held command onto the unit's operation
   always_comb begin
      unique case (cmd_ff)
         sev_pkg::CMD_ADD: alu_op = sev_pkg::ALU_ADD;
         sev_pkg::CMD_MUL: alu_op = sev_pkg::ALU_MUL;
         sev_pkg::CMD_MOD: alu_op = sev_pkg::ALU_MOD;
         default:          alu_op = sev_pkg::ALU_NONE;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      b_in          = b_ff;
      top_in        = top_ff;
      pend_emit_in  = pend_emit_ff;
      pend_value_in = pend_value_ff;
      pend_jump_in  = pend_jump_ff;
      pend_fault_in = pend_fault_ff;
      rsp_data_in   = rsp_data_ff;
      // drop the held result once it is taken
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;

      wr_en   = 1'b0;
      wr_addr = top_ff[AW-1:0];
      wr_data = req_operand;
      rd_en   = 1'b0;
      rd_addr = top_m1[AW-1:0];

      alu_req.start = 1'b0;
      alu_req.op    = alu_op;
      alu_req.a     = rd_data;
      alu_req.b     = b_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cmd_in        = req_cmd;
               pend_emit_in  = 1'b0;
               pend_value_in = '0;
               pend_jump_in  = 1'b0;
               pend_fault_in = sev_pkg::FAULT_NONE;
               state_in      = S_DONE;
               unique case (req_cmd)
                  sev_pkg::CMD_PUSH: begin
                     // a full stack drops the value
                     if (top_ff == TOP_FULL) begin
                        pend_fault_in = sev_pkg::FAULT_OVER;
                     end else begin
                        wr_en  = 1'b1;
                        top_in = top_ff + TW'(1);
                     end
                  end
                  sev_pkg::CMD_ADD, sev_pkg::CMD_MUL, sev_pkg::CMD_MOD: begin
                     if (top_ff < TW'(2)) begin
                        pend_fault_in = sev_pkg::FAULT_UNDER;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_RDA;
                     end
                  end
                  sev_pkg::CMD_CPOP, sev_pkg::CMD_PRINT: begin
                     if (top_ff == TW'(0)) begin
                        pend_fault_in = sev_pkg::FAULT_UNDER;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_RDU;
                     end
                  end
                  default: begin
                     // nop and the unused code leave everything at zero
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_RDA: begin
            b_in     = rd_data;
            rd_en    = 1'b1;
            rd_addr  = top_m2[AW-1:0];
            state_in = S_OPS;
         end
         S_OPS: begin
            // modulo by zero leaves both operands in place
            if (cmd_ff == sev_pkg::CMD_MOD && b_ff == '0) begin
               pend_fault_in = sev_pkg::FAULT_DIVZ;
               state_in      = S_DONE;
            end else begin
               alu_req.start = 1'b1;
               state_in      = S_ALU;
            end
         end
         S_ALU: begin
            if (alu_rsp.done) begin
               wr_en    = 1'b1;
               wr_addr  = top_m2[AW-1:0];
               wr_data  = alu_rsp.result;
               top_in   = top_m1;
               state_in = S_DONE;
            end
         end
         S_RDU: begin
            top_in = top_m1;
            if (cmd_ff == sev_pkg::CMD_PRINT) begin
               pend_emit_in  = 1'b1;
               pend_value_in = rd_data;
            end else begin
               pend_jump_in = (rd_data == '0);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold here while the output register is still occupied
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{sev_pkg::RSP_PAD_W{1'b0}}, pend_fault_ff, pend_jump_ff,
                               pend_value_ff, pend_emit_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      b_ff          <= b_in;
      pend_emit_ff  <= pend_emit_in;
      pend_value_ff <= pend_value_in;
      pend_jump_ff  <= pend_jump_in;
      pend_fault_ff <= pend_fault_in;
      rsp_data_ff   <= rsp_data_in;
   end

   sev_stack_ram #(
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sev_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SEV_ASSERT(a_top_in_range, clock, reset, top_ff <= TOP_FULL)
   `SEV_ASSERT_NEXT(a_full_push_keeps_top, clock, reset,
      req_accept && req_cmd == sev_pkg::CMD_PUSH && top_ff == TOP_FULL, $stable(top_ff))
   `SEV_ASSERT_IMPLY(a_alu_done_in_wait, clock, reset, alu_rsp.done, state_ff == S_ALU)
   `SEV_ASSERT_NEXT(a_done_loads_output, clock, reset,
      state_ff == S_DONE && out_free, rsp_valid_ff && state_ff == S_IDLE)
   `SEV_ASSERT_IMPLY(a_fault_has_no_emit, clock, reset,
      rsp_valid_ff && rsp_tdata[35:34] != sev_pkg::FAULT_NONE, !rsp_tdata[0])

endmodule

/* verif/stack_evaluator_tb.sv */
// Self-checking testbench for the stack evaluator: directed, fill-and-drain and random programs.
`timescale 1ns / 100ps

module stack_evaluator_tb;

   localparam int               STACK_DEPTH  = 256;
   localparam int               HALF_PERIOD  = 5;
   localparam int               ITEM_TARGET  = 1050;
   // The slowest item is mod; cycles to wait on after the last expected result.
   localparam int               DRAIN_CYCLES = 60;
   localparam longint           TIMEOUT_NS   = 5_000_000;
   localparam sev_pkg::cmd_type CMD_UNUSED   = 3'd7;

   typedef struct packed {
      logic               emit_valid;
      sev_pkg::word_type  emit_value;
      logic               take_jump;
      sev_pkg::fault_type fault;
   } eval_result_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_LONG
   } stall_mode_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   // [2:0] cmd, [34:3] operand_value, [39:35] zero
   logic [sev_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // [0] emit_valid, [32:1] emit_value, [33] take_jump, [35:34] fault, [39:36] zero
   logic [sev_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // Shadow copy of the machine state, updated as each item is accepted.
   sev_pkg::word_type      stack_mem [STACK_DEPTH];
   int unsigned            stack_count = 0;
   eval_result_type        pending_results [$];
   eval_result_type        oldest_result;
   int unsigned            mismatch_count = 0;
   int unsigned            items_sent     = 0;

   // Sender burst bookkeeping.
   int unsigned            burst_left = 0;

   // Receiver stall pattern.
   stall_mode_type         stall_mode  = STALL_NONE;
   int unsigned            mode_left   = 0;
   int unsigned            stall_left  = 0;
   int unsigned            stall_phase = 0;

   stack_evaluator #(
      .STACK_DEPTH(STACK_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Execute one instruction on the shadow stack and return what the block must report.
   function automatic eval_result_type execute_instruction(input sev_pkg::cmd_type op,
                                                           input sev_pkg::word_type value);
      eval_result_type   res;
      sev_pkg::word_type lhs;
      sev_pkg::word_type rhs;
      sev_pkg::word_type acc;
      longint            num;
      longint            den;
      res = '0;
      case (op)
         sev_pkg::CMD_PUSH: begin
            if (stack_count >= STACK_DEPTH) begin
               res.fault = sev_pkg::FAULT_OVER;
            end else begin
               stack_mem[stack_count] = value;
               stack_count++;
            end
         end
         sev_pkg::CMD_ADD, sev_pkg::CMD_MUL, sev_pkg::CMD_MOD: begin
            if (stack_count < 2) begin
               res.fault = sev_pkg::FAULT_UNDER;
            end else begin
               lhs = stack_mem[stack_count-2];
               rhs = stack_mem[stack_count-1];
               if (op == sev_pkg::CMD_MOD && rhs == '0) begin
                  // Divide by zero: both operands stay put.
                  res.fault = sev_pkg::FAULT_DIVZ;
               end else begin
                  if (op == sev_pkg::CMD_ADD) begin
                     acc = lhs + rhs;
                  end else if (op == sev_pkg::CMD_MUL) begin
                     acc = lhs * rhs;
                  end else begin
                     // 64-bit remainder truncates toward zero and cannot overflow,
                     // so minimum modulo minus one comes out as zero.
                     num = longint'(signed'(lhs));
                     den = longint'(signed'(rhs));
                     acc = num % den;
                  end
                  stack_mem[stack_count-2] = acc;
                  stack_count--;
               end
            end
         end
         sev_pkg::CMD_CPOP: begin
            if (stack_count < 1) begin
               res.fault = sev_pkg::FAULT_UNDER;
            end else begin
               stack_count--;
               res.take_jump = (stack_mem[stack_count] == '0);
            end
         end
         sev_pkg::CMD_PRINT: begin
            if (stack_count < 1) begin
               res.fault = sev_pkg::FAULT_UNDER;
            end else begin
               stack_count--;
               res.emit_valid = 1'b1;
               res.emit_value = stack_mem[stack_count];
            end
         end
         default: begin
            // nop and the unused code leave everything alone
         end
      endcase
      return res;
   endfunction

   // Operand with a bias toward the corners of the 32-bit range and small values.
   function automatic sev_pkg::word_type random_operand();
      int small_val;
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         4, 5: begin
            small_val = int'($urandom_range(0, 20)) - 10;
            return small_val;
         end
         default: return $urandom;
      endcase
   endfunction

   // Send one item: drive at the falling edge, hold until accepted, then predict its result.
   task automatic send_item(input sev_pkg::cmd_type op, input sev_pkg::word_type value);
      int unsigned gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {{sev_pkg::REQ_PAD_W{1'b0}}, value, op};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(execute_instruction(op, value));
      if (op != sev_pkg::CMD_NOP && op != CMD_UNUSED) begin
         items_sent++;
      end
   endtask

   // Hit every command on an empty stack, the wrap cases, underflow and divide by zero.
   task automatic test_directed();
      send_item(sev_pkg::CMD_NOP,    $urandom);
      send_item(CMD_UNUSED,          $urandom);
      send_item(sev_pkg::CMD_ADD,    $urandom);
      send_item(sev_pkg::CMD_MUL,    $urandom);
      send_item(sev_pkg::CMD_MOD,    $urandom);
      send_item(sev_pkg::CMD_CPOP,   $urandom);
      send_item(sev_pkg::CMD_PRINT,  $urandom);
      send_item(sev_pkg::CMD_PUSH,   32'h7FFF_FFFF);
      send_item(sev_pkg::CMD_ADD,    $urandom);   // one entry only: underflow
      send_item(sev_pkg::CMD_PUSH,   32'd1);
      send_item(sev_pkg::CMD_ADD,    $urandom);   // wraps to the minimum value
      send_item(sev_pkg::CMD_PUSH,   32'hFFFF_FFFF);
      send_item(sev_pkg::CMD_MOD,    $urandom);   // minimum modulo minus one
      send_item(sev_pkg::CMD_CPOP,   $urandom);   // zero on top: branch taken
      send_item(sev_pkg::CMD_PUSH,   -32'sd7);
      send_item(sev_pkg::CMD_PUSH,   32'd0);
      send_item(sev_pkg::CMD_MOD,    $urandom);   // divide by zero, stack kept
      send_item(sev_pkg::CMD_CPOP,   $urandom);
      send_item(sev_pkg::CMD_PUSH,   32'd3);
      send_item(sev_pkg::CMD_MOD,    $urandom);   // negative dividend keeps its sign
      send_item(sev_pkg::CMD_PRINT,  $urandom);
      send_item(sev_pkg::CMD_PUSH,   32'h8000_0000);
      send_item(sev_pkg::CMD_PUSH,   32'h8000_0000);
      send_item(sev_pkg::CMD_MUL,    $urandom);   // product wraps to zero
      send_item(sev_pkg::CMD_PUSH,   -32'sd3);
      send_item(sev_pkg::CMD_MOD,    $urandom);   // zero dividend leaves zero
      send_item(sev_pkg::CMD_PUSH,   32'd5);
      send_item(sev_pkg::CMD_CPOP,   $urandom);   // nonzero on top: not taken
   endtask

   // Fill the stack to the top, push past it, then drain with random arithmetic.
   task automatic test_overflow();
      sev_pkg::cmd_type op;
      while (stack_count < STACK_DEPTH) begin
         send_item(sev_pkg::CMD_PUSH, random_operand());
      end
      send_item(sev_pkg::CMD_PUSH,  random_operand());
      send_item(sev_pkg::CMD_PUSH,  random_operand());
      send_item(sev_pkg::CMD_PRINT, $urandom);
      send_item(sev_pkg::CMD_PUSH,  random_operand());
      send_item(sev_pkg::CMD_PUSH,  random_operand());
      while (stack_count != 0) begin
         case ($urandom_range(0, 9))
            0:       op = sev_pkg::CMD_PUSH;
            1, 2:    op = sev_pkg::CMD_ADD;
            3, 4:    op = sev_pkg::CMD_MUL;
            5, 6:    op = sev_pkg::CMD_MOD;
            7:       op = sev_pkg::CMD_CPOP;
            default: op = sev_pkg::CMD_PRINT;
         endcase
         send_item(op, (op == sev_pkg::CMD_PUSH) ? random_operand()
                                                 : sev_pkg::word_type'($urandom));
      end
   endtask

   // Mostly well-formed programs of shallow depth, with some noise that underflows.
   task automatic test_random();
      sev_pkg::cmd_type op;
      int unsigned      roll;
      while (items_sent < ITEM_TARGET) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            op = sev_pkg::cmd_type'($urandom_range(0, 7));
         end else if (stack_count < 2 || (roll < 45 && stack_count < 16)) begin
            op = sev_pkg::CMD_PUSH;
         end else begin
            case ($urandom_range(0, 7))
               0, 1:    op = sev_pkg::CMD_ADD;
               2, 3:    op = sev_pkg::CMD_MUL;
               4, 5:    op = sev_pkg::CMD_MOD;
               6:       op = sev_pkg::CMD_CPOP;
               default: op = sev_pkg::CMD_PRINT;
            endcase
         end
         send_item(op, (op == sev_pkg::CMD_PUSH) ? random_operand()
                                                 : sev_pkg::word_type'($urandom));
      end
   endtask

   // Receiver: switch between randomly chosen stall patterns.
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(16, 96);
      end
      mode_left--;
      stall_phase++;
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            STALL_NONE:     rsp_tready <= 1'b1;
            STALL_RANDOM:   rsp_tready <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: rsp_tready <= ((stall_phase % 5) < 2);
            default: begin
               if ($urandom_range(0, 15) == 0) begin
                  stall_left = $urandom_range(4, 20);
               end
               rsp_tready <= (stall_left == 0);
            end
         endcase
      end
   end

   // Compare every accepted result with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result with no item outstanding: rsp_tdata %h", rsp_tdata);
            mismatch_count++;
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_tdata[0] !== oldest_result.emit_valid) begin
               $error("emit_valid: expected %0b, got %0b",
                      oldest_result.emit_valid, rsp_tdata[0]);
               mismatch_count++;
            end
            if (rsp_tdata[32:1] !== oldest_result.emit_value) begin
               $error("emit_value: expected %h, got %h",
                      oldest_result.emit_value, rsp_tdata[32:1]);
               mismatch_count++;
            end
            if (rsp_tdata[33] !== oldest_result.take_jump) begin
               $error("take_jump: expected %0b, got %0b",
                      oldest_result.take_jump, rsp_tdata[33]);
               mismatch_count++;
            end
            if (rsp_tdata[35:34] !== oldest_result.fault) begin
               $error("fault: expected %0d, got %0d",
                      oldest_result.fault, rsp_tdata[35:34]);
               mismatch_count++;
            end
            if (rsp_tdata[sev_pkg::RSP_TDATA_W-1:36] !== '0) begin
               $error("rsp_tdata padding: expected 0, got %h",
                      rsp_tdata[sev_pkg::RSP_TDATA_W-1:36]);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_overflow();
      test_random();

      // Drop valid once the last item is in, then wait out the remaining results.
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(TIMEOUT_NS);
      $display("TB_ERROR");
      $finish;
   end

endmodule
